/* sv/rfr_pkg.sv */
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared constants of the RFID reader frame receiver: sizes, byte positions,
// event codes and configuration register indexes.
// ----------------------------------------------------------------------------
package rfr_pkg;

  localparam int FRAME_BYTES = 32;
  localparam int ID_BYTES    = 12;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

  // byte positions inside a frame
  localparam int POS_CMD   = 2;
  localparam int POS_ERR   = 5;
  localparam int POS_LEN_H = 3;
  localparam int POS_LEN_L = 4;
  localparam int CKSUM_BASE = 5;
  localparam int ID_FIRST  = 9;

  localparam int ADDR_W = 5;

  // event codes
  localparam logic [3:0] EV_OTHER_OK  = 4'd0;
  localparam logic [3:0] EV_NEW_TAG   = 4'd1;
  localparam logic [3:0] EV_SAME_TAG  = 4'd2;
  localparam logic [3:0] EV_REMOVED   = 4'd3;
  localparam logic [3:0] EV_CMD_ERR   = 4'd4;
  localparam logic [3:0] EV_FAILURE   = 4'd5;
  localparam logic [3:0] EV_BAD_SUM   = 4'd6;
  localparam logic [3:0] EV_BAD_FRAME = 4'd7;
  localparam logic [3:0] EV_OVERFLOW  = 4'd8;

  // configuration register indexes
  localparam logic [2:0] REG_HEADER    = 3'd0;
  localparam logic [2:0] REG_END       = 3'd1;
  localparam logic [2:0] REG_POLL      = 3'd2;
  localparam logic [2:0] REG_FAILURE   = 3'd3;
  localparam logic [2:0] REG_INV_FAIL  = 3'd4;
  localparam logic [2:0] REG_CMD_ERR   = 3'd5;

  typedef logic [7:0] byte_t;
  typedef byte_t [ID_BYTES-1:0] tag_id_t;

endpackage

/* sv/rfr_if.sv */
// ----------------------------------------------------------------------------
// rfr interfaces
// Valid/ready channels of the frame receiver: received bytes in, events out.
// ----------------------------------------------------------------------------
interface rfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfr_evt_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [7:0]  command;
  logic [7:0]  error_code;
  logic [31:0] tag_id_high;
  logic [63:0] tag_id_low;

  modport source (output valid, output event_res, output command, output error_code,
                  output tag_id_high, output tag_id_low, input ready);
  modport sink   (input valid, input event_res, input command, input error_code,
                  input tag_id_high, input tag_id_low, output ready);
endinterface

/* sv/rfid_reader_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// rfid_reader_frame_receiver_core
// Collects reader response bytes into frames, checks header and checksum,
// and reports tag and error events.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle; a byte that closes a frame
// (or exceeds the frame length limit) yields one event beat in the output
// register on the next cycle. The frame is parsed on the fly as bytes arrive:
// only the header, command, length, error, checksum and tag ID bytes are kept, so
// no frame memory is needed. The event register stays loaded until it is
// taken, and new bytes are accepted whenever it is empty or being emptied.
// The tag ID store is cleared by reset.
module rfid_reader_frame_receiver_core
  import rfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  rfr_rx_if.sink            rx,
  rfr_evt_if.source         evt
);

  // configuration
  byte_t header_byte, end_byte, single_poll_code, failure_code;
  byte_t inventory_fail_code, command_error_code;

  // frame state
  logic [CNT_W-1:0] byte_count, byte_count_next;
  byte_t            running_sum, running_sum_next;
  logic [15:0]      param_length, param_length_next;
  logic             overflowed, overflowed_next;
  byte_t            first_b, cmd_b, err_b, cksum_b;
  tag_id_t          id_cap;
  tag_id_t          tag_id_store, tag_id_next;

  // per-beat logic
  logic        accept, is_end, emit;
  logic [3:0]  ev;
  byte_t       b, first_v, cmd_v, err_v, cksum_v, sum_v;
  logic [16:0] cpos, p_ext;
  tag_id_t     id_frame;
  logic        id_blank;
  logic [31:0] hi_v;
  logic [63:0] lo_v;
  logic        evt_valid;

  assign pready = 1'b1;
  assign accept = rx.valid && rx.ready;
  assign rx.ready = !evt_valid || evt.ready;
  assign evt.valid = evt_valid;
  assign b = rx.rx_byte;
  assign is_end = (b == end_byte);
  assign p_ext = 17'(byte_count);
  assign cpos = 17'(param_length) + 17'(CKSUM_BASE);

  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      REG_HEADER:   prdata = 32'(header_byte);
      REG_END:      prdata = 32'(end_byte);
      REG_POLL:     prdata = 32'(single_poll_code);
      REG_FAILURE:  prdata = 32'(failure_code);
      REG_INV_FAIL: prdata = 32'(inventory_fail_code);
      REG_CMD_ERR:  prdata = 32'(command_error_code);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte         <= 8'hAA;
      end_byte            <= 8'hDD;
      single_poll_code    <= 8'h22;
      failure_code        <= 8'hFF;
      inventory_fail_code <= 8'h15;
      command_error_code  <= 8'h17;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_HEADER:   header_byte         <= pwdata[7:0];
        REG_END:      end_byte            <= pwdata[7:0];
        REG_POLL:     single_poll_code    <= pwdata[7:0];
        REG_FAILURE:  failure_code        <= pwdata[7:0];
        REG_INV_FAIL: inventory_fail_code <= pwdata[7:0];
        REG_CMD_ERR:  command_error_code  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // current byte overlaid on the captured fields
  always_comb begin
    first_v = (byte_count == CNT_W'(0)) ? b : first_b;
    cmd_v   = (byte_count == CNT_W'(POS_CMD)) ? b : cmd_b;
    err_v   = (byte_count == CNT_W'(POS_ERR)) ? b : err_b;
    cksum_v = (p_ext == cpos) ? b : cksum_b;
    for (int j = 0; j < ID_BYTES; j++) begin
      id_frame[j] = (byte_count == CNT_W'(ID_FIRST + j)) ? b : id_cap[j];
    end
    id_blank = (tag_id_store == '0);
  end

  always_comb begin
    byte_count_next   = byte_count;
    running_sum_next  = running_sum;
    param_length_next = param_length;
    overflowed_next   = overflowed;
    tag_id_next       = tag_id_store;
    emit              = 1'b0;
    ev                = EV_OTHER_OK;
    sum_v             = running_sum;
    if (accept) begin
      if (overflowed) begin
        if (is_end) begin
          overflowed_next   = 1'b0;
          byte_count_next   = '0;
          running_sum_next  = '0;
          param_length_next = '0;
        end
      end else if (byte_count >= CNT_W'(FRAME_BYTES)) begin
        emit              = 1'b1;
        ev                = EV_OVERFLOW;
        byte_count_next   = '0;
        running_sum_next  = '0;
        param_length_next = '0;
        overflowed_next   = !is_end;
      end else begin
        byte_count_next = byte_count + CNT_W'(1);
        if (byte_count == CNT_W'(POS_LEN_H)) begin
          param_length_next = {b, 8'h00};
        end else if (byte_count == CNT_W'(POS_LEN_L)) begin
          param_length_next = {param_length[15:8], b};
        end
        if (byte_count != '0 &&
            (byte_count <= CNT_W'(POS_LEN_L) || p_ext + 17'd1 <= cpos)) begin
          sum_v = running_sum + b;
        end
        running_sum_next = sum_v;
        if (is_end) begin
          emit              = 1'b1;
          byte_count_next   = '0;
          running_sum_next  = '0;
          param_length_next = '0;
          if (byte_count == '0 || first_v != header_byte) begin
            ev = EV_BAD_FRAME;
          end else if (byte_count < CNT_W'(POS_LEN_L) || cpos > p_ext) begin
            ev = EV_BAD_SUM;
          end else if (cksum_v != sum_v) begin
            ev = EV_BAD_SUM;
          end else if (cmd_v == single_poll_code) begin
            if (p_ext < 17'(ID_FIRST + ID_BYTES - 1)) begin
              ev = EV_BAD_FRAME;
            end else if (id_frame != tag_id_store) begin
              tag_id_next = id_frame;
              ev          = EV_NEW_TAG;
            end else begin
              ev = EV_SAME_TAG;
            end
          end else if (cmd_v == failure_code) begin
            if (err_v == command_error_code) begin
              ev = EV_CMD_ERR;
            end else if (err_v == inventory_fail_code && !id_blank) begin
              tag_id_next = '0;
              ev          = EV_REMOVED;
            end else begin
              ev = EV_FAILURE;
            end
          end else begin
            ev = EV_OTHER_OK;
          end
        end
      end
    end
  end

  // big-endian packing of the stored ID
  always_comb begin
    hi_v = '0;
    lo_v = '0;
    for (int i = 0; i < ID_BYTES; i++) begin
      if (ID_BYTES - 1 - i < 8) begin
        lo_v[8*(ID_BYTES-1-i) +: 8] = tag_id_next[i];
      end else if (ID_BYTES - 1 - i < 12) begin
        hi_v[8*(ID_BYTES-9-i) +: 8] = tag_id_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      running_sum  <= '0;
      param_length <= '0;
      overflowed   <= 1'b0;
      tag_id_store <= '0;
      evt_valid    <= 1'b0;
    end else begin
      byte_count   <= byte_count_next;
      running_sum  <= running_sum_next;
      param_length <= param_length_next;
      overflowed   <= overflowed_next;
      tag_id_store <= tag_id_next;
      if (emit) begin
        evt_valid <= 1'b1;
      end else if (evt.ready) begin
        evt_valid <= 1'b0;
      end
    end
  end

  // captured frame bytes
  always_ff @(posedge clk) begin
    if (accept && !overflowed && byte_count < CNT_W'(FRAME_BYTES)) begin
      if (byte_count == '0) first_b <= b;
      if (byte_count == CNT_W'(POS_CMD)) cmd_b <= b;
      if (byte_count == CNT_W'(POS_ERR)) err_b <= b;
      if (byte_count >= CNT_W'(CKSUM_BASE) && p_ext == cpos) cksum_b <= b;
      id_cap <= id_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      evt.event_res   <= ev;
      evt.command     <= (byte_count >= CNT_W'(POS_CMD)) ? cmd_v : 8'h00;
      evt.error_code  <= (byte_count >= CNT_W'(POS_ERR)) ? err_v : 8'h00;
      evt.tag_id_high <= hi_v;
      evt.tag_id_low  <= lo_v;
    end
  end

endmodule
